FILE: design/assert_macros.svh
// assertion macros shared by the boundary extract rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define BBE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition in one cycle implies another in the next
`define BBE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/bbe_pkg.sv
// shared constants, types and helpers of the binary boundary extract block
package bbe_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int RING_AW_DEF    = $clog2(2 * MAX_WIDTH_DEF + 4);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int LUMA_W     = 8;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

	localparam logic KIND_PIXEL = 1'b0;

	localparam logic [LUMA_W-1:0]     THRESH_RST = 8'd128;
	localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 11'd534;
	localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 11'd566;
	localparam logic [LUMA_W-1:0]     EDGE_ON    = 8'd255;
	localparam logic [LUMA_W-1:0]     EDGE_OFF   = 8'd0;

	// three consecutive binary pixels: [2] newest, [0] oldest
	typedef logic [2:0] row_word_t;

	// per-row request handed from the control stage to a row cell
	typedef struct packed {
		logic      ovr_sel;
		row_word_t ovr_word;
		row_word_t mask;
	} row_req_t;

	// align the newest stored triple to a row that ends past the newest pixel
	function automatic row_word_t ovr_shift(row_word_t word, logic [1:0] span);
		row_word_t res;
		case (span)
			2'd0: res = word;
			2'd1: res = word >> 1;
			2'd2: res = word >> 2;
			default: res = '0;
		endcase
		return res;
	endfunction

endpackage

FILE: design/bbe_row_cell.sv
// one window row: its own copy of the pixel ring plus the row register and its erosion term
module bbe_row_cell #(
	parameter int AW = bbe_pkg::RING_AW_DEF
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  bbe_pkg::row_word_t wr_word,
	input  logic               ld,
	input  logic [AW-1:0]      rd_addr,
	input  bbe_pkg::row_req_t  req,
	input  logic               and_in,
	output logic               and_out,
	output bbe_pkg::row_word_t row
);
	import bbe_pkg::*;

	localparam int DEPTH = 1 << AW;

	row_word_t mem [DEPTH];
	row_word_t rd_s1;
	row_req_t  req_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			rd_s1  <= mem[rd_addr];
			req_s1 <= req;
		end
	end

	// pixels outside the frame or not yet arrived read as background
	assign row     = (req_s1.ovr_sel ? req_s1.ovr_word : rd_s1) & req_s1.mask;
	assign and_out = and_in & (&row);

endmodule

FILE: design/binary_boundary_extract_3x3.sv
// top level of the binary boundary extract block (threshold, 3x3 erosion, difference)
//
// Usage: luma words enter on in_valid/in_stall with kind = pixel, in raster
// order; a kind = flush word carries no pixel and pushes out the oldest
// waiting result. Results leave on out_valid/out_stall as edge_value
// (255 on a boundary pixel, 0 elsewhere) with frame_last on the final pixel.
// A pixel's result is released by the input word one line plus one pixel
// later (or by a flush); it passes through the window stage register and
// then the output register, which takes it once out_stall lets it, and
// out_valid rises as the output register loads it. One word per clock
// is sustained while in_stall is low: each of the three row cells does
// one ring read per word, and a single write per pixel keeps them full.
// Configuration (threshold, frame_width, frame_height) is written on the
// cfg port while the block is idle; sizes are clamped to 1..MAX.
// Reset clears the counters, the pipeline and the registers to 128/534/566;
// the pixel ring needs no clearing pass and is never read before written.
// When out_stall holds a word in the output register, one more word can be
// taken into the window stage; with both full, in_stall rises in the same
// cycle as out_stall and nothing is lost.
module binary_boundary_extract_3x3 #(
	parameter int MAX_WIDTH  = bbe_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bbe_pkg::MAX_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [bbe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bbe_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             kind,
	input  logic [bbe_pkg::LUMA_W-1:0]       luma,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [bbe_pkg::LUMA_W-1:0]       edge_value,
	output logic                             frame_last
);
	import bbe_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int PW = $clog2(MAX_WIDTH + 3);
	localparam int AW = $clog2(2 * MAX_WIDTH + 4);
	localparam int DW = PW + 2;
	localparam int W_RST = (int'(WIDTH_RST) > MAX_WIDTH) ? MAX_WIDTH : int'(WIDTH_RST);
	localparam int H_RST = (int'(HEIGHT_RST) > MAX_HEIGHT) ? MAX_HEIGHT : int'(HEIGHT_RST);

	// configuration
	logic [LUMA_W-1:0] thr_q;
	logic [WW-1:0]     w_q;
	logic [HW-1:0]     h_q;
	logic [WW-1:0]     w_clamp;
	logic [HW-1:0]     h_clamp;

	// stream state
	logic [AW-1:0] n_q;
	logic [PW-1:0] pending_q;
	logic [CW-1:0] ocol_q;
	logic [RW-1:0] orow_q;
	row_word_t     last_word_q;

	// word entry
	logic          acc;
	logic          pix;
	logic          emit;
	logic          bin;
	logic [PW-1:0] pend_inc;
	row_word_t     new_word;
	row_word_t     latest;
	logic [AW-1:0] p_addr;
	logic [AW-1:0] rd_addr [3];
	row_req_t      req [3];
	logic [2:0]    colok;
	logic [2:0]    rowok;
	logic          last_now;
	logic          col_wrap;
	logic          row_wrap;
	logic          ld;

	// window stage and output
	logic          v_s1;
	logic          last_s1;
	logic [3:0]    chain;
	row_word_t     rows [3];
	logic          edge_s1;
	logic          out_free;
	logic          out_v_q;
	logic [LUMA_W-1:0] edge_q;
	logic          flast_q;

	always_comb begin
		if (cfg_data == '0) begin
			w_clamp = WW'(1);
		end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
			w_clamp = WW'(MAX_WIDTH);
		end else begin
			w_clamp = WW'(cfg_data);
		end
		if (cfg_data == '0) begin
			h_clamp = HW'(1);
		end else if (32'(cfg_data) > 32'(MAX_HEIGHT)) begin
			h_clamp = HW'(MAX_HEIGHT);
		end else begin
			h_clamp = HW'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESH_RST;
			w_q   <= WW'(W_RST);
			h_q   <= HW'(H_RST);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q <= cfg_data[LUMA_W-1:0];
				REG_WIDTH:     w_q   <= w_clamp;
				REG_HEIGHT:    h_q   <= h_clamp;
				default: ;
			endcase
		end
	end

	assign out_free = !out_v_q || !out_stall;
	assign in_stall = v_s1 && out_v_q && out_stall;
	assign acc      = in_valid && !in_stall;
	assign pix      = (kind == KIND_PIXEL);
	assign pend_inc = pending_q + PW'(pix);
	assign emit     = pix ? (pend_inc > (PW'(w_q) + PW'(1))) : (pending_q != '0);
	assign ld       = acc && emit;
	assign bin      = (luma >= thr_q);
	assign new_word = {bin, last_word_q[2:1]};
	assign latest   = pix ? new_word : last_word_q;

	// stream index of the result pixel and the last index of each window row
	assign p_addr     = n_q - AW'(pending_q);
	assign rd_addr[0] = p_addr - AW'(w_q) + AW'(1);
	assign rd_addr[1] = p_addr + AW'(1);
	assign rd_addr[2] = p_addr + AW'(w_q) + AW'(1);

	assign colok[0] = (ocol_q != '0) && (WW'(ocol_q) <= w_q);
	assign colok[1] = WW'(ocol_q) < w_q;
	assign colok[2] = (WW'(ocol_q) + WW'(1)) < w_q;
	assign rowok[0] = (orow_q != '0) && (HW'(orow_q) <= h_q);
	assign rowok[1] = HW'(orow_q) < h_q;
	assign rowok[2] = (HW'(orow_q) + HW'(1)) < h_q;

	assign last_now = (HW'(orow_q) == h_q - HW'(1)) && (WW'(ocol_q) == w_q - WW'(1));
	assign col_wrap = (WW'(ocol_q) + WW'(1)) >= w_q;
	assign row_wrap = (HW'(orow_q) + HW'(1)) >= h_q;

	// distance of each row end past the newest pixel; at or past it the row
	// comes from the newest stored triple rather than the ring
	always_comb begin
		logic [DW-1:0] w_x;
		logic [DW-1:0] pi_x;
		logic [DW-1:0] diff [3];
		w_x     = DW'(w_q);
		pi_x    = DW'(pend_inc);
		diff[0] = DW'(2) - w_x - pi_x;
		diff[1] = DW'(2) - pi_x;
		diff[2] = w_x + DW'(2) - pi_x;
		for (int k = 0; k < 3; k++) begin
			req[k].ovr_sel  = !diff[k][DW-1];
			req[k].ovr_word = ovr_shift(latest, (diff[k] > DW'(2)) ? 2'd3 : diff[k][1:0]);
			req[k].mask     = colok & {3{rowok[k]}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			pending_q   <= '0;
			ocol_q      <= '0;
			orow_q      <= '0;
			last_word_q <= '0;
		end else if (acc) begin
			if (pix) begin
				n_q         <= n_q + AW'(1);
				last_word_q <= new_word;
			end
			pending_q <= emit ? (pend_inc - PW'(1)) : pend_inc;
			if (emit) begin
				if (col_wrap) begin
					ocol_q <= '0;
					orow_q <= row_wrap ? '0 : (orow_q + RW'(1));
				end else begin
					ocol_q <= ocol_q + CW'(1);
				end
			end
		end
	end

	assign chain[0] = 1'b1;

	for (genvar k = 0; k < 3; k++) begin : g_row
		bbe_row_cell #(
			.AW(AW)
		) u_cell (
			.clk     (clk),
			.wr_en   (acc && pix),
			.wr_addr (n_q),
			.wr_word (new_word),
			.ld      (ld),
			.rd_addr (rd_addr[k]),
			.req     (req[k]),
			.and_in  (chain[k]),
			.and_out (chain[k+1]),
			.row     (rows[k])
		);
	end

	// boundary: centre set and not every neighbour set
	assign edge_s1 = rows[1][1] && !chain[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= emit;
		end else if (out_free) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			last_s1 <= last_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s1) begin
			edge_q  <= edge_s1 ? EDGE_ON : EDGE_OFF;
			flast_q <= last_s1;
		end
	end

	assign out_valid  = out_v_q;
	assign edge_value = edge_q;
	assign frame_last = flast_q;

`include "assert_macros.svh"

	`BBE_ASSERT(a_pend_bound, pending_q <= PW'(MAX_WIDTH + 2), "pending count beyond a line plus two")
	`BBE_ASSERT_NEXT(a_emit_loads, acc && emit, v_s1, "released word missing from window stage")
	`BBE_ASSERT_NEXT(a_full_hold, v_s1 && out_v_q && out_stall, v_s1 && out_v_q, "stalled pipeline dropped a word")

endmodule

FILE: tb/sv/binary_boundary_extract_3x3_test.sv
// self-checking testbench of the binary boundary extract block
`timescale 1ns / 1ps

module binary_boundary_extract_3x3_test;
	import bbe_pkg::*;

	localparam int RING_SLOTS = 2 * MAX_WIDTH_DEF + 4;
	localparam logic KIND_FLUSH = ~KIND_PIXEL;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [LUMA_W-1:0] edge_value;
		logic              last;
	} boundary_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  kind = KIND_PIXEL;
	logic [LUMA_W-1:0]     luma = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [LUMA_W-1:0]     edge_value;
	logic                  frame_last;

	// predictor state: registers, binary pixel ring and result position
	logic [LUMA_W-1:0]     thr_now = THRESH_RST;
	logic [CFG_DATA_W-1:0] width_reg = WIDTH_RST;
	logic [CFG_DATA_W-1:0] height_reg = HEIGHT_RST;
	bit                    fg_ring [RING_SLOTS];
	int                    ring_wr = 0;
	int                    waiting_px = 0;
	int                    oldest_col = 0;
	int                    oldest_row = 0;

	boundary_t boundary_q [$];
	int        fails = 0;
	int        words = 0;
	bit        send_gaps = 1'b1;
	bit        recv_gaps = 1'b1;
	int        stall_left = 0;
	int        hold_left = 0;

	binary_boundary_extract_3x3 uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.luma       (luma),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.edge_value (edge_value),
		.frame_last (frame_last)
	);

	always #5 clk = ~clk;

	function automatic int frame_dim(logic [CFG_DATA_W-1:0] v, int top);
		if (v == 0)
			return 1;
		if (v > top)
			return top;
		return int'(v);
	endfunction

	// boundary bit of the oldest waiting pixel, then step the result position
	function automatic boundary_t boundary_of_oldest(int w, int h);
		boundary_t res;
		bit [8:0]  win;
		int        base, r, c, off, k, dr, dc;
		base = ring_wr + 2 * RING_SLOTS - waiting_px;
		win = '0;
		k = 0;
		for (dr = -1; dr <= 1; dr++) begin
			for (dc = -1; dc <= 1; dc++) begin
				r = oldest_row + dr;
				c = oldest_col + dc;
				off = dr * w + dc;
				// neighbours off the frame or not yet arrived count as background
				if (r >= 0 && r < h && c >= 0 && c < w && off < waiting_px)
					win[k] = fg_ring[(base + off + RING_SLOTS) % RING_SLOTS];
				k++;
			end
		end
		res.edge_value = (win[4] && win != 9'h1FF) ? EDGE_ON : EDGE_OFF;
		res.last = (oldest_row == h - 1 && oldest_col == w - 1);
		oldest_col++;
		if (oldest_col >= w) begin
			oldest_col = 0;
			oldest_row++;
			if (oldest_row >= h)
				oldest_row = 0;
		end
		waiting_px--;
		return res;
	endfunction

	function automatic void track_word(logic k, logic [LUMA_W-1:0] l);
		int w, h;
		w = frame_dim(width_reg, MAX_WIDTH_DEF);
		h = frame_dim(height_reg, MAX_HEIGHT_DEF);
		if (k == KIND_PIXEL) begin
			fg_ring[ring_wr] = (l >= thr_now);
			ring_wr = (ring_wr + 1) % RING_SLOTS;
			waiting_px++;
			if (waiting_px > w + 1)
				boundary_q.push_back(boundary_of_oldest(w, h));
		end else if (waiting_px > 0) begin
			boundary_q.push_back(boundary_of_oldest(w, h));
		end
	endfunction

	function automatic logic [LUMA_W-1:0] luma_for(int fg_pct);
		if ($urandom_range(9) == 0 || thr_now == 0)
			return LUMA_W'($urandom_range(255));
		if ($urandom_range(99) < fg_pct)
			return LUMA_W'($urandom_range(255, thr_now));
		return LUMA_W'($urandom_range(thr_now - 1, 0));
	endfunction

	task automatic set_frame(input logic [LUMA_W-1:0] thr, input logic [CFG_DATA_W-1:0] w,
			input logic [CFG_DATA_W-1:0] h);
		cfg_write <= 1'b1;
		cfg_index <= REG_THRESHOLD;
		cfg_data <= CFG_DATA_W'(thr);
		@(posedge clk);
		cfg_index <= REG_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		// the spare index must leave every register alone
		cfg_index <= REG_SPARE;
		cfg_data <= CFG_DATA_W'($urandom);
		@(posedge clk);
		cfg_write <= 1'b0;
		thr_now = thr;
		width_reg = w;
		height_reg = h;
	endtask

	task automatic send_word(input logic k, input logic [LUMA_W-1:0] l);
		int gap;
		if (send_gaps && $urandom_range(3) == 0) begin
			gap = $urandom_range(6, 1);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		luma <= l;
		do
			@(posedge clk);
		while (in_stall);
		track_word(k, l);
		words++;
	endtask

	task automatic flush_all;
		while (waiting_px > 0)
			send_word(KIND_FLUSH, LUMA_W'($urandom_range(255)));
	endtask

	// wait for every expected word, then cover the pipeline depth
	task automatic drain;
		in_valid <= 1'b0;
		while (boundary_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic test_reset_values;
		send_word(KIND_FLUSH, 8'd255);
		send_word(KIND_PIXEL, 8'd127);
		send_word(KIND_PIXEL, 8'd128);
		send_word(KIND_PIXEL, 8'd0);
		send_word(KIND_PIXEL, 8'd255);
		flush_all();
		drain();
	endtask

	task automatic test_small_extremes;
		int i;
		// everything is foreground: only the centre of a 3x3 frame erodes
		set_frame(8'd0, 11'd3, 11'd3);
		for (i = 0; i < 9; i++)
			send_word(KIND_PIXEL, i[0] ? 8'd255 : 8'd0);
		flush_all();
		drain();
		// zero sizes act as a one pixel frame
		set_frame(8'd255, 11'd0, 11'd0);
		send_word(KIND_PIXEL, 8'd255);
		send_word(KIND_PIXEL, 8'd254);
		send_word(KIND_PIXEL, 8'd255);
		flush_all();
		drain();
	endtask

	// widths beyond the maximum clamp, so a result needs a full line plus two pixels
	task automatic test_widest_line;
		set_frame(LUMA_W'($urandom_range(200, 60)), 11'd2047, 11'd1024);
		repeat (1030) send_word(KIND_PIXEL, luma_for(75));
		repeat (20) send_word(KIND_FLUSH, LUMA_W'($urandom_range(255)));
		drain();
	endtask

	task automatic test_random_frames;
		logic [LUMA_W-1:0]     thr;
		logic [CFG_DATA_W-1:0] w_reg, h_reg;
		int                    start, frames, fg, pixels, i;
		start = words;
		while (words - start < 120) begin
			case ($urandom_range(7))
				0: thr = 8'd0;
				1: thr = 8'd255;
				default: thr = LUMA_W'($urandom_range(255));
			endcase
			w_reg = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(40, 0)) :
				CFG_DATA_W'($urandom_range(10, 0));
			h_reg = CFG_DATA_W'($urandom_range(6, 0));
			set_frame(thr, w_reg, h_reg);
			send_gaps = ($urandom_range(3) != 0);
			recv_gaps = ($urandom_range(3) != 0);
			fg = $urandom_range(100, 40);
			pixels = frame_dim(w_reg, MAX_WIDTH_DEF) * frame_dim(h_reg, MAX_HEIGHT_DEF);
			frames = (pixels > 100) ? 1 : $urandom_range(3, 1);
			// whole frames back to back, with the odd stray flush
			for (i = 0; i < frames * pixels; i++) begin
				if ($urandom_range(39) == 0)
					send_word(KIND_FLUSH, LUMA_W'($urandom_range(255)));
				send_word(KIND_PIXEL, luma_for(fg));
			end
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(pixels)) send_word(KIND_PIXEL, luma_for(fg));
			// sometimes pixels stay behind and the next sizes apply mid-frame
			if ($urandom_range(4) != 0) begin
				flush_all();
				if ($urandom_range(3) == 0)
					send_word(KIND_FLUSH, LUMA_W'($urandom_range(255)));
			end
			drain();
		end
	endtask

	task automatic test_output_hold_off;
		set_frame(8'd128, 11'd4, 11'd4);
		send_gaps = 1'b0;
		recv_gaps = 1'b1;
		hold_left = 150;
		repeat (80) send_word(KIND_PIXEL, luma_for(70));
		drain();
	endtask

	task automatic test_steady_stream;
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		set_frame(LUMA_W'($urandom_range(255)), 11'd7, 11'd5);
		repeat (70) send_word(KIND_PIXEL, luma_for(80));
		flush_all();
		drain();
	endtask

	// receiver: random stall bursts, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (recv_gaps && $urandom_range(4) == 0) begin
			stall_left = $urandom_range(6, 1) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_words
		boundary_t want;
		if (out_valid && !out_stall) begin
			if (boundary_q.size() == 0) begin
				$error("unexpected word: edge_value %0d, frame_last %0d", edge_value,
					frame_last);
				fails++;
			end else begin
				want = boundary_q.pop_front();
				if (edge_value !== want.edge_value) begin
					$error("edge_value: expected %0d, actual %0d", want.edge_value,
						edge_value);
					fails++;
				end
				if (frame_last !== want.last) begin
					$error("frame_last: expected %0d, actual %0d", want.last, frame_last);
					fails++;
				end
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_small_extremes();
		test_random_frames();
		test_output_hold_off();
		test_steady_stream();
		test_widest_line();
		if (fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
